// ----- src/rtcc_pkg.sv -----
// Package: types, constants and calendar helper functions for the RTC calendar counter.
`default_nettype none

package rtcc_pkg;

	// Sub-second units that make up one second
	localparam int unsigned UNITS_PER_SECOND = 1000000;

	localparam int SUB_W   = 20;
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DAY_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;

	localparam logic [SEC_W-1:0]   SECS_PER_MIN  = SEC_W'(60);
	localparam logic [MIN_W-1:0]   MINS_PER_HOUR = MIN_W'(60);
	localparam logic [HOUR_W-1:0]  HOURS_PER_DAY = HOUR_W'(24);
	localparam logic [WDAY_W-1:0]  WDAY_SUNDAY   = WDAY_W'(6);

	// Month codes, zero based
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(0);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(3);
	localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(5);
	localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(8);
	localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(10);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(11);

	// Item function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SET  = 1'b1;

	// Divisibility by 25 through the modular inverse of 25 over 16 bits
	localparam logic [YEAR_W-1:0] INV25_16   = 16'h5C29;
	localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(65535 / 25);

	typedef struct packed {
		logic                func;
		logic [SEC_W-1:0]    set_second;
		logic [MIN_W-1:0]    set_minute;
		logic [HOUR_W-1:0]   set_hour;
		logic [DAY_W-1:0]    set_day;
		logic [WDAY_W-1:0]   set_weekday;
		logic [MONTH_W-1:0]  set_month;
		logic [YEAR_W-1:0]   set_year;
	} item_t;

	// Result beat; also the layout of the calendar state itself
	typedef struct packed {
		logic [SEC_W-1:0]    second;
		logic [MIN_W-1:0]    minute;
		logic [HOUR_W-1:0]   hour;
		logic [DAY_W-1:0]    day;
		logic [WDAY_W-1:0]   weekday;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
		logic [SUB_W-1:0]    subsecond;
		logic                leap;
	} result_t;

	// Gregorian leap rule: multiple of 4, and not of 100 unless of 400
	function automatic logic leap_of(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0]   prod;
		logic                div25;
		prod  = y * INV25_16;
		div25 = (prod <= DIV25_LIMIT);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	// Days in a month; codes past December count as 31-day months
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                             input logic leap);
		logic [DAY_W-1:0] len;
		len = DAY_W'(31);
		if (m == MONTH_FEB) begin
			len = leap ? DAY_W'(29) : DAY_W'(28);
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
		             m == MONTH_NOV) begin
			len = DAY_W'(30);
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- src/rtcc_step.sv -----
// Next-state logic: applies one tick or set item to the calendar state.
`default_nettype none

module rtcc_step (
	input  wire rtcc_pkg::result_t           cur,
	input  wire rtcc_pkg::item_t             item,
	input  wire [rtcc_pkg::SUB_W-1:0]        tick_inc,
	output rtcc_pkg::result_t                nxt
);

	localparam logic [rtcc_pkg::SUB_W:0] UPS =
		(rtcc_pkg::SUB_W + 1)'(rtcc_pkg::UNITS_PER_SECOND);

	logic [rtcc_pkg::SUB_W:0]     sum;
	logic [rtcc_pkg::SUB_W:0]     sum_less;
	logic                         sec_carry;
	logic [rtcc_pkg::SEC_W-1:0]   sec_inc;
	logic [rtcc_pkg::MIN_W-1:0]   min_inc;
	logic [rtcc_pkg::HOUR_W-1:0]  hour_inc;
	logic [rtcc_pkg::DAY_W-1:0]   day_inc;
	logic [rtcc_pkg::DAY_W-1:0]   len;
	logic [rtcc_pkg::YEAR_W-1:0]  year_inc;
	logic [rtcc_pkg::YEAR_W-1:0]  year_sel;
	logic                         leap_sel;

	// Accumulate sub-second units; take one second off at most
	assign sum       = {1'b0, cur.subsecond} + {1'b0, tick_inc};
	assign sum_less  = sum - UPS;
	assign sec_carry = (sum >= UPS);

	// Wrapping increments of each count
	assign sec_inc  = cur.second + rtcc_pkg::SEC_W'(1);
	assign min_inc  = cur.minute + rtcc_pkg::MIN_W'(1);
	assign hour_inc = cur.hour + rtcc_pkg::HOUR_W'(1);
	assign day_inc  = cur.day + rtcc_pkg::DAY_W'(1);
	assign year_inc = cur.year + rtcc_pkg::YEAR_W'(1);
	assign len      = rtcc_pkg::month_len(cur.month, cur.leap);

	// One leap evaluator serves both the loaded year and the next year
	assign year_sel = (item.func == rtcc_pkg::FUNC_SET) ? item.set_year : year_inc;
	assign leap_sel = rtcc_pkg::leap_of(year_sel);

	// Apply the item
	always_comb begin
		nxt = cur;
		if (item.func == rtcc_pkg::FUNC_SET) begin
			nxt.second  = item.set_second;
			nxt.minute  = item.set_minute;
			nxt.hour    = item.set_hour;
			nxt.day     = item.set_day;
			nxt.weekday = item.set_weekday;
			nxt.month   = item.set_month;
			nxt.year    = item.set_year;
			nxt.leap    = leap_sel;
		end else begin
			nxt.subsecond = sec_carry ? sum_less[rtcc_pkg::SUB_W-1:0]
			                          : sum[rtcc_pkg::SUB_W-1:0];
			if (sec_carry) begin
				if (sec_inc < rtcc_pkg::SECS_PER_MIN) begin
					nxt.second = sec_inc;
				end else begin
					nxt.second = sec_inc - rtcc_pkg::SECS_PER_MIN;
					if (min_inc < rtcc_pkg::MINS_PER_HOUR) begin
						nxt.minute = min_inc;
					end else begin
						nxt.minute = min_inc - rtcc_pkg::MINS_PER_HOUR;
						if (hour_inc < rtcc_pkg::HOURS_PER_DAY) begin
							nxt.hour = hour_inc;
						end else begin
							// Roll over to the next day
							nxt.hour    = hour_inc - rtcc_pkg::HOURS_PER_DAY;
							nxt.weekday = (cur.weekday >= rtcc_pkg::WDAY_SUNDAY) ?
							              rtcc_pkg::WDAY_W'(0) :
							              cur.weekday + rtcc_pkg::WDAY_W'(1);
							if (day_inc < len) begin
								nxt.day = day_inc;
							end else begin
								nxt.day = day_inc - len;
								if (cur.month == rtcc_pkg::MONTH_DEC) begin
									nxt.month = rtcc_pkg::MONTH_JAN;
									nxt.year  = year_inc;
									nxt.leap  = leap_sel;
								end else begin
									nxt.month = cur.month + rtcc_pkg::MONTH_W'(1);
								end
							end
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/rtc_calendar_counter.sv -----
// Top level: real-time clock calendar counter with valid/stall channels.
// A beat is captured in the stage-1 register, then moves into the result
// register, which presents it until it is taken.
// Throughput: one item per cycle while the result channel does not stall; the
// combinational next-state update of the calendar registers sets that rate.
// Reset (arst_n low, asynchronous) clears the calendar, the accumulator,
// the tick increment and both stage valids.
`default_nettype none

module rtc_calendar_counter (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [rtcc_pkg::SUB_W-1:0]   cfg_wdata,
	input  wire                         item_valid,
	output logic                        item_stall,
	input  wire rtcc_pkg::item_t        item,
	output logic                        result_valid,
	input  wire                         result_stall,
	output rtcc_pkg::result_t           result
);

	logic [rtcc_pkg::SUB_W-1:0] tick_inc_q;
	rtcc_pkg::result_t          cal_q;
	rtcc_pkg::result_t          cal_next;
	rtcc_pkg::item_t            item_s1;
	logic                       valid_s1;
	rtcc_pkg::result_t          result_s2;
	logic                       valid_s2;
	logic                       advance;
	logic                       item_take;

	// Move the stage-1 beat into the result register when it has room
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take  = item_valid && !item_stall;

	// Hold the tick increment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_inc_q <= '0;
		end else if (cfg_we) begin
			tick_inc_q <= cfg_wdata;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	rtcc_step u_step (
		.cur      (cal_q),
		.item     (item_s1),
		.tick_inc (tick_inc_q),
		.nxt      (cal_next)
	);

	// Advance the calendar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (advance) begin
			cal_q <= cal_next;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= cal_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Input stalls only while a beat waits in stage 1
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	// A processed beat always shows up as a result
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed beat not presented");

	// The calendar changes only when a beat is processed
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cal_q))
		else $error("calendar changed without a beat");

	// A result under stall is not overwritten by a new beat
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !advance)
		else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ----- tb/sv/rtc_calendar_counter_test.sv -----
// Self-checking testbench for rtc_calendar_counter: calendar rollovers under random handshake pressure.
`timescale 1ns / 100ps

module rtc_calendar_counter_test;

	localparam int QUIET_LIMIT = 4000;
	localparam int SUBPHASE_ITEMS = 74;
	// month and weekday values past the legal range, loaded on purpose
	localparam logic [rtcc_pkg::MONTH_W-1:0] MONTH_PAST_DEC = rtcc_pkg::MONTH_W'(12);
	localparam logic [rtcc_pkg::MONTH_W-1:0] MONTH_TOP = rtcc_pkg::MONTH_W'(15);
	localparam logic [rtcc_pkg::WDAY_W-1:0] WDAY_TOP = rtcc_pkg::WDAY_W'(7);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rtcc_pkg::SUB_W-1:0] cfg_wdata = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	rtcc_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	rtcc_pkg::result_t result;

	// shadow of the calendar and of the tick increment register
	rtcc_pkg::result_t shadow_clock = '0;
	logic [rtcc_pkg::SUB_W-1:0] shadow_increment = '0;

	rtcc_pkg::item_t pending_items[$];
	rtcc_pkg::result_t due_times[$];
	int items_outstanding = 0;
	int items_queued = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int settings_used = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	rtc_calendar_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in(input logic [rtcc_pkg::MONTH_W-1:0] m,
		input bit lp);
		case (m)
			rtcc_pkg::MONTH_FEB: return lp ? 29 : 28;
			rtcc_pkg::MONTH_APR, rtcc_pkg::MONTH_JUN, rtcc_pkg::MONTH_SEP,
			rtcc_pkg::MONTH_NOV: return 30;
			default: return 31;
		endcase
	endfunction

	// advance one day: weekday, month and year carries
	function automatic rtcc_pkg::result_t roll_day(input rtcc_pkg::result_t t);
		int unsigned len;
		t.day = t.day + 1'b1;
		t.weekday = (t.weekday >= rtcc_pkg::WDAY_SUNDAY) ? '0 : t.weekday + 1'b1;
		len = days_in(t.month, t.leap);
		if (32'(t.day) >= len) begin
			t.day = t.day - rtcc_pkg::DAY_W'(len);
			if (t.month == rtcc_pkg::MONTH_DEC) begin
				t.month = rtcc_pkg::MONTH_JAN;
				t.year = t.year + 1'b1;
				t.leap = leap_year(32'(t.year));
			end else begin
				t.month = t.month + 1'b1;
			end
		end
		return t;
	endfunction

	// advance one second; each carry takes its modulus off once
	function automatic rtcc_pkg::result_t roll_second(input rtcc_pkg::result_t t);
		t.second = t.second + 1'b1;
		if (t.second >= rtcc_pkg::SECS_PER_MIN) begin
			t.second = t.second - rtcc_pkg::SECS_PER_MIN;
			t.minute = t.minute + 1'b1;
			if (t.minute >= rtcc_pkg::MINS_PER_HOUR) begin
				t.minute = t.minute - rtcc_pkg::MINS_PER_HOUR;
				t.hour = t.hour + 1'b1;
				if (t.hour >= rtcc_pkg::HOURS_PER_DAY) begin
					t.hour = t.hour - rtcc_pkg::HOURS_PER_DAY;
					t = roll_day(t);
				end
			end
		end
		return t;
	endfunction

	// calendar after one beat: either a load or a tick
	function automatic rtcc_pkg::result_t next_time_of(input rtcc_pkg::result_t t,
		input rtcc_pkg::item_t it);
		int unsigned sum;
		if (it.func == rtcc_pkg::FUNC_SET) begin
			t.second = it.set_second;
			t.minute = it.set_minute;
			t.hour = it.set_hour;
			t.day = it.set_day;
			t.weekday = it.set_weekday;
			t.month = it.set_month;
			t.year = it.set_year;
			t.leap = leap_year(32'(it.set_year));
		end else begin
			sum = 32'(t.subsecond) + 32'(shadow_increment);
			if (sum >= rtcc_pkg::UNITS_PER_SECOND) begin
				sum = sum - rtcc_pkg::UNITS_PER_SECOND;
				t = roll_second(t);
			end
			t.subsecond = sum[rtcc_pkg::SUB_W-1:0];
		end
		return t;
	endfunction

	function automatic rtcc_pkg::item_t set_item(input int unsigned s, input int unsigned mi,
		input int unsigned h, input int unsigned d, input int unsigned wd,
		input int unsigned mo, input int unsigned y);
		rtcc_pkg::item_t it;
		it.func = rtcc_pkg::FUNC_SET;
		it.set_second = rtcc_pkg::SEC_W'(s);
		it.set_minute = rtcc_pkg::MIN_W'(mi);
		it.set_hour = rtcc_pkg::HOUR_W'(h);
		it.set_day = rtcc_pkg::DAY_W'(d);
		it.set_weekday = rtcc_pkg::WDAY_W'(wd);
		it.set_month = rtcc_pkg::MONTH_W'(mo);
		it.set_year = rtcc_pkg::YEAR_W'(y);
		return it;
	endfunction

	// tick with random garbage in the load fields
	function automatic rtcc_pkg::item_t tick_item();
		rtcc_pkg::item_t it;
		it = $bits(rtcc_pkg::item_t)'({$urandom, $urandom});
		it.func = rtcc_pkg::FUNC_TICK;
		return it;
	endfunction

	function automatic int unsigned pick_year();
		case ($urandom_range(0, 6))
			0: return 1900;
			1: return 2000;
			2: return 2100;
			3: return 2400;
			4: return 0;
			5: return 65535;
			default: return 2024;
		endcase
	endfunction

	task automatic queue_item(input rtcc_pkg::item_t it);
		pending_items.push_back(it);
		items_outstanding++;
		items_queued++;
	endtask

	// wait for every result, then let the pipeline settle
	task automatic drain();
		while (items_outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tick_increment(input logic [rtcc_pkg::SUB_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_increment = v;
		settings_used++;
	endtask

	// load just before a rollover, then tick through it
	task automatic queue_rollover_run();
		logic [rtcc_pkg::MONTH_W-1:0] m;
		int unsigned y;
		int unsigned len;
		int n;
		m = rtcc_pkg::MONTH_W'($urandom_range(0, 11));
		y = $urandom_range(0, 1) ? pick_year() : $urandom_range(0, 65535);
		len = days_in(m, leap_year(y));
		queue_item(set_item($urandom_range(55, 59), $urandom_range(58, 59),
			$urandom_range(22, 23), len - 1 - $urandom_range(0, 1),
			$urandom_range(0, 6), 32'(m), y));
		n = $urandom_range(1, 8);
		repeat (n) queue_item(tick_item());
	endtask

	task automatic queue_random_run();
		rtcc_pkg::item_t it;
		int n;
		if ($urandom_range(0, 1)) begin
			it = $bits(rtcc_pkg::item_t)'({$urandom, $urandom});
			it.func = rtcc_pkg::FUNC_SET;
			queue_item(it);
		end
		n = $urandom_range(1, 6);
		repeat (n) queue_item(tick_item());
	endtask

	// present beats from the pending queue; hold a stalled beat
	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			shadow_clock = next_time_of(shadow_clock, item);
			due_times.push_back(shadow_clock);
		end
		if (!item_valid || !item_stall) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// stall the result channel at random
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		rtcc_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_times.size() == 0) begin
				$error("result beat with no prediction pending");
				mismatch_count++;
			end else begin
				want = due_times.pop_front();
				compare_field("second", 32'(want.second), 32'(result.second));
				compare_field("minute", 32'(want.minute), 32'(result.minute));
				compare_field("hour", 32'(want.hour), 32'(result.hour));
				compare_field("day", 32'(want.day), 32'(result.day));
				compare_field("weekday", 32'(want.weekday), 32'(result.weekday));
				compare_field("month", 32'(want.month), 32'(result.month));
				compare_field("year", 32'(want.year), 32'(result.year));
				compare_field("subsecond", 32'(want.subsecond), 32'(result.subsecond));
				compare_field("leap", 32'(want.leap), 32'(result.leap));
				results_checked++;
				items_outstanding--;
			end
		end
	end

	// drop the run when no beat moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [rtcc_pkg::SUB_W-1:0] step;
		int start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: one second per tick
		write_tick_increment(rtcc_pkg::SUB_W'(rtcc_pkg::UNITS_PER_SECOND));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 30, 6, 32'(rtcc_pkg::MONTH_DEC), 1999));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 27, 1, 32'(rtcc_pkg::MONTH_FEB), 2000));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 28, 2, 32'(rtcc_pkg::MONTH_FEB), 2000));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 27, 3, 32'(rtcc_pkg::MONTH_FEB), 1900));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 27, 4, 32'(rtcc_pkg::MONTH_FEB), 2100));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 28, 5, 32'(rtcc_pkg::MONTH_FEB), 2400));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 29, 0, 32'(rtcc_pkg::MONTH_APR), 2023));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 30, 6, 32'(rtcc_pkg::MONTH_DEC), 65535));
		queue_item(tick_item());
		// wrap of saturated fields, then single carries of out-of-range values
		queue_item(set_item(63, 63, 31, 31, 32'(WDAY_TOP), 32'(MONTH_TOP), 65535));
		queue_item(tick_item());
		queue_item(set_item(60, 60, 24, 31, 32'(WDAY_TOP), 32'(MONTH_PAST_DEC), 4));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 30, 5, 32'(MONTH_PAST_DEC), 100));
		queue_item(tick_item());
		queue_item(set_item(59, 59, 23, 30, 0, 32'(MONTH_TOP), 7));
		queue_item(tick_item());
		drain();
		// zero, oversized and minimal increments
		write_tick_increment('0);
		repeat (2) queue_item(tick_item());
		drain();
		write_tick_increment('1);
		repeat (3) queue_item(tick_item());
		drain();
		write_tick_increment(rtcc_pkg::SUB_W'(1));
		repeat (2) queue_item(tick_item());

		// random: rollover runs mostly, random loads and tick bursts otherwise
		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: step = '1;
				1: step = rtcc_pkg::SUB_W'(rtcc_pkg::UNITS_PER_SECOND);
				2: step = rtcc_pkg::SUB_W'(rtcc_pkg::UNITS_PER_SECOND - 1);
				3: step = rtcc_pkg::SUB_W'($urandom_range(900000, 1048575));
				4: step = rtcc_pkg::SUB_W'($urandom);
				5: step = rtcc_pkg::SUB_W'(rtcc_pkg::UNITS_PER_SECOND);
				6: step = rtcc_pkg::SUB_W'($urandom_range(500000, 1000000));
				default: step = rtcc_pkg::SUB_W'($urandom_range(990000, 1010000));
			endcase
			write_tick_increment(step);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 83;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 83;
				end
				default: begin
					idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			start = items_queued;
			while (items_queued - start < SUBPHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 70) begin
					queue_rollover_run();
				end else begin
					queue_random_run();
				end
			end
		end
		drain();

		$display("covered %0d beats over %0d increment settings, %0d results checked",
			items_queued, settings_used, results_checked);
		$display("mismatches: %0d, predictions left over: %0d", mismatch_count,
			due_times.size());
		if (mismatch_count == 0 && due_times.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
